@@ rtl/core/prsu_pkg.sv @@
// shared types, codes and constants of the picture processor register and scroll unit
package prsu_pkg;

    localparam int SPRITE_MEM_DEPTH_DEF = 256;

    // action codes
    localparam logic [3:0] ACT_READ         = 4'd0;
    localparam logic [3:0] ACT_WRITE        = 4'd1;
    localparam logic [3:0] ACT_INC_HORZ     = 4'd2;
    localparam logic [3:0] ACT_INC_VERT     = 4'd3;
    localparam logic [3:0] ACT_COPY_HORZ    = 4'd4;
    localparam logic [3:0] ACT_COPY_VERT    = 4'd5;
    localparam logic [3:0] ACT_VBLANK_ON    = 4'd6;
    localparam logic [3:0] ACT_VBLANK_OFF   = 4'd7;
    localparam logic [3:0] ACT_SET_HIT      = 4'd8;
    localparam logic [3:0] ACT_SET_OVERFLOW = 4'd9;

    // register indexes
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [13:0] PALETTE_BASE   = 14'h3F00;
    localparam logic [4:0]  COARSE_LAST    = 5'd31;
    localparam logic [4:0]  COARSE_ROW_END = 5'd29;
    localparam logic [2:0]  FINE_Y_LAST    = 3'd7;
    localparam logic [2:0]  STATUS_RESET   = 3'b101;

    typedef struct packed {
        logic [3:0] action;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] mem_read_data;
        logic       oam_write_allowed;
    } req_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [13:0] mem_addr;
        logic        mem_read;
        logic        mem_write;
        logic [14:0] vram_address;
        logic [2:0]  fine_scroll_x;
        logic        nmi_request;
        logic [5:0]  control_bits;
        logic [7:0]  mask_bits;
    } rsp_item_t;

endpackage

@@ rtl/core/prsu_oam.sv @@
// sprite memory with per-entry valid bits and a registered read port
module prsu_oam #(
    parameter int DEPTH = prsu_pkg::SPRITE_MEM_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : 8'd0;

endmodule

@@ rtl/core/ppu_register_scroll_unit.sv @@
// top level: cpu register file and loopy scroll/address unit
// an accepted item passes the input register, then the result register
// one item per cycle unless stalled; sprite memory is read ahead at the next sprite address
// reset: all control state and scroll registers cleared, status holds vblank and overflow set
// reset: sprite memory entries read as zero until written (valid bits cleared at reset)
module ppu_register_scroll_unit #(
    parameter int SPRITE_MEM_DEPTH = prsu_pkg::SPRITE_MEM_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  prsu_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output prsu_pkg::rsp_item_t rsp
);

    localparam int OAM_AW = $clog2(SPRITE_MEM_DEPTH);

    logic                in_valid_reg;
    prsu_pkg::req_item_t in_item_reg;
    logic                rsp_valid_reg;
    prsu_pkg::rsp_item_t rsp_reg;
    prsu_pkg::rsp_item_t rsp_next;
    logic                advance;

    logic [14:0]       cur_addr_reg,  cur_addr_next;
    logic [14:0]       tmp_addr_reg,  tmp_addr_next;
    logic [2:0]        fine_x_reg,    fine_x_next;
    logic              toggle_reg,    toggle_next;
    logic [5:0]        ctrl_reg,      ctrl_next;
    logic [7:0]        mask_reg,      mask_next;
    logic [2:0]        status_reg,    status_next;
    logic [OAM_AW-1:0] oam_addr_reg,  oam_addr_next;
    logic [7:0]        rbuf_reg,      rbuf_next;
    logic [7:0]        latch_reg,     latch_next;

    logic        oam_wr_en;
    logic [7:0]  oam_rd_data;
    logic [14:0] data_step;
    logic [13:0] maddr;
    logic        mrd;
    logic        mwr;
    logic        nmi;
    logic [4:0]  tile_row;

    assign advance   = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign data_step = ctrl_reg[0] ? 15'd32 : 15'd1;
    assign tile_row  = cur_addr_reg[9:5];

    always_comb
    begin
        cur_addr_next = cur_addr_reg;
        tmp_addr_next = tmp_addr_reg;
        fine_x_next   = fine_x_reg;
        toggle_next   = toggle_reg;
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        oam_addr_next = oam_addr_reg;
        rbuf_next     = rbuf_reg;
        latch_next    = latch_reg;
        oam_wr_en     = 1'b0;
        maddr         = 14'd0;
        mrd           = 1'b0;
        mwr           = 1'b0;
        nmi           = 1'b0;
        if (advance)
        begin
            unique case (in_item_reg.action)
                prsu_pkg::ACT_READ:
                begin
                    unique case (in_item_reg.reg_index)
                        prsu_pkg::REG_STATUS:
                        begin
                            latch_next     = {status_reg, latch_reg[4:0]};
                            status_next[2] = 1'b0;
                            toggle_next    = 1'b0;
                        end
                        prsu_pkg::REG_OAM_DATA:
                        begin
                            latch_next = oam_rd_data;
                        end
                        prsu_pkg::REG_DATA:
                        begin
                            maddr = cur_addr_reg[13:0];
                            mrd   = 1'b1;
                            if (maddr < prsu_pkg::PALETTE_BASE)
                            begin
                                latch_next = rbuf_reg;
                                rbuf_next  = in_item_reg.mem_read_data;
                            end
                            else
                            begin
                                latch_next = in_item_reg.mem_read_data;
                            end
                            cur_addr_next = cur_addr_reg + data_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                prsu_pkg::ACT_WRITE:
                begin
                    latch_next = in_item_reg.write_data;
                    unique case (in_item_reg.reg_index)
                        prsu_pkg::REG_CTRL:
                        begin
                            tmp_addr_next[11:10] = in_item_reg.write_data[1:0];
                            ctrl_next            = in_item_reg.write_data[7:2];
                        end
                        prsu_pkg::REG_MASK:
                        begin
                            mask_next = in_item_reg.write_data;
                        end
                        prsu_pkg::REG_OAM_ADDR:
                        begin
                            oam_addr_next = in_item_reg.write_data[OAM_AW-1:0];
                        end
                        prsu_pkg::REG_OAM_DATA:
                        begin
                            if (in_item_reg.oam_write_allowed)
                            begin
                                oam_wr_en     = 1'b1;
                                oam_addr_next = oam_addr_reg + 1'b1;
                            end
                        end
                        prsu_pkg::REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                tmp_addr_next[4:0] = in_item_reg.write_data[7:3];
                                fine_x_next        = in_item_reg.write_data[2:0];
                            end
                            else
                            begin
                                tmp_addr_next[9:5]   = in_item_reg.write_data[7:3];
                                tmp_addr_next[14:12] = in_item_reg.write_data[2:0];
                            end
                            toggle_next = !toggle_reg;
                        end
                        prsu_pkg::REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                tmp_addr_next = {1'b0, in_item_reg.write_data[5:0],
                                                 tmp_addr_reg[7:0]};
                            end
                            else
                            begin
                                tmp_addr_next = {tmp_addr_reg[14:8], in_item_reg.write_data};
                                cur_addr_next = {tmp_addr_reg[14:8], in_item_reg.write_data};
                            end
                            toggle_next = !toggle_reg;
                        end
                        prsu_pkg::REG_DATA:
                        begin
                            maddr         = cur_addr_reg[13:0];
                            mwr           = 1'b1;
                            cur_addr_next = cur_addr_reg + data_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                prsu_pkg::ACT_INC_HORZ:
                begin
                    if (cur_addr_reg[4:0] == prsu_pkg::COARSE_LAST)
                    begin
                        cur_addr_next[4:0] = 5'd0;
                        cur_addr_next[10]  = !cur_addr_reg[10];
                    end
                    else
                    begin
                        cur_addr_next[4:0] = cur_addr_reg[4:0] + 5'd1;
                    end
                end
                prsu_pkg::ACT_INC_VERT:
                begin
                    if (cur_addr_reg[14:12] != prsu_pkg::FINE_Y_LAST)
                    begin
                        cur_addr_next[14:12] = cur_addr_reg[14:12] + 3'd1;
                    end
                    else
                    begin
                        cur_addr_next[14:12] = 3'd0;
                        if (tile_row == prsu_pkg::COARSE_ROW_END)
                        begin
                            cur_addr_next[9:5] = 5'd0;
                            cur_addr_next[11]  = !cur_addr_reg[11];
                        end
                        else if (tile_row == prsu_pkg::COARSE_LAST)
                        begin
                            cur_addr_next[9:5] = 5'd0;
                        end
                        else
                        begin
                            cur_addr_next[9:5] = tile_row + 5'd1;
                        end
                    end
                end
                prsu_pkg::ACT_COPY_HORZ:
                begin
                    cur_addr_next[10]  = tmp_addr_reg[10];
                    cur_addr_next[4:0] = tmp_addr_reg[4:0];
                end
                prsu_pkg::ACT_COPY_VERT:
                begin
                    cur_addr_next[14:11] = tmp_addr_reg[14:11];
                    cur_addr_next[9:5]   = tmp_addr_reg[9:5];
                end
                prsu_pkg::ACT_VBLANK_ON:
                begin
                    status_next[2] = 1'b1;
                    nmi            = ctrl_reg[5];
                end
                prsu_pkg::ACT_VBLANK_OFF:
                begin
                    status_next = 3'd0;
                end
                prsu_pkg::ACT_SET_HIT:
                begin
                    status_next[1] = 1'b1;
                end
                prsu_pkg::ACT_SET_OVERFLOW:
                begin
                    status_next[0] = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_next.read_data     = latch_next;
        rsp_next.mem_addr      = maddr;
        rsp_next.mem_read      = mrd;
        rsp_next.mem_write     = mwr;
        rsp_next.vram_address  = cur_addr_next;
        rsp_next.fine_scroll_x = fine_x_next;
        rsp_next.nmi_request   = nmi;
        rsp_next.control_bits  = ctrl_next;
        rsp_next.mask_bits     = mask_next;
    end

    prsu_oam #(
        .DEPTH (SPRITE_MEM_DEPTH),
        .AW    (OAM_AW)
    ) u_oam (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oam_wr_en),
        .wr_addr (oam_addr_reg),
        .wr_data (in_item_reg.write_data),
        .rd_addr (oam_addr_next),
        .rd_data (oam_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            cur_addr_reg  <= '0;
            tmp_addr_reg  <= '0;
            fine_x_reg    <= '0;
            toggle_reg    <= 1'b0;
            ctrl_reg      <= '0;
            mask_reg      <= '0;
            status_reg    <= prsu_pkg::STATUS_RESET;
            oam_addr_reg  <= '0;
            rbuf_reg      <= '0;
            latch_reg     <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            cur_addr_reg <= cur_addr_next;
            tmp_addr_reg <= tmp_addr_next;
            fine_x_reg   <= fine_x_next;
            toggle_reg   <= toggle_next;
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            oam_addr_reg <= oam_addr_next;
            rbuf_reg     <= rbuf_next;
            latch_reg    <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_item_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

@@ rtl/core/prsu_checker.sv @@
// port-level checks of the register and scroll unit, bound to the top level
module prsu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input prsu_pkg::rsp_item_t rsp
);

    // a stalled item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    a_one_port_access: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.mem_read && rsp.mem_write))
        else $error("data port read and write in one item");

    a_nmi_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.nmi_request |-> !rsp.mem_read && !rsp.mem_write)
        else $error("nmi request together with a data port access");

    a_addr_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.mem_read && !rsp.mem_write |-> rsp.mem_addr == 14'd0)
        else $error("memory address set without a data port access");

endmodule

bind ppu_register_scroll_unit prsu_checker u_prsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
